FILE: rtl/core/iprl_pkg.sv
package iprl_pkg;

   // Table size and port count of the routing table.
   localparam int ROUTES = 16;
   localparam int PORTS  = 4;

   // Field widths.
   localparam int ADDR_W     = 32;
   localparam int TTL_W      = 8;
   localparam int PORT_W     = 2;
   localparam int METRIC_W   = 5;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Slot index width used to address the table.
   localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;

   // The selection tree is padded to a power of two and its levels are split
   // over three pipeline stages.
   localparam int TREE_LVL = (ROUTES > 1) ? $clog2(ROUTES) : 0;
   localparam int LEAVES   = 1 << TREE_LVL;
   localparam int LVL_S1   = TREE_LVL / 4;
   localparam int LVL_S3   = TREE_LVL / 4;
   localparam int LVL_S2   = TREE_LVL - LVL_S1 - LVL_S3;
   localparam int W1       = LEAVES >> LVL_S1;
   localparam int W2       = W1 >> LVL_S2;

   // Request actions.
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // Register map, as word indexes, and reset values.
   localparam logic REG_INFINITY = 1'b0;
   localparam logic [METRIC_W-1:0] INFINITY_RESET = METRIC_W'(16);

   // Minimum TTL that may still be forwarded.
   localparam logic [TTL_W-1:0] TTL_MIN_FWD = TTL_W'(2);

   typedef enum logic [STATUS_W-1:0] {
      ST_FORWARD       = 2'd0,
      ST_TIME_EXCEEDED = 2'd1,
      ST_NO_ROUTE      = 2'd2
   } status_type;

   // One candidate route travelling through the selection tree.
   typedef struct packed {
      logic                hit;
      logic [ADDR_W-1:0]   mask;
      logic [ADDR_W-1:0]   gateway;
      logic [PORT_W-1:0]   port;
      logic [METRIC_W-1:0] metric;
   } cand_type;

   // Merge two neighbors; the higher slot wins on an equal mask.
   function automatic cand_type pick(cand_type lo, cand_type hi);
      cand_type res;
      if (hi.hit && (!lo.hit || (hi.mask >= lo.mask))) begin
         res = hi;
      end else begin
         res = lo;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/ipv4_route_lookup_core.sv
// Longest prefix match lookup over a register table of iprl_pkg::ROUTES routes.
// A lookup passes the s1, s2, s3 and output registers before its response shows.
// Throughput: one request per cycle unless rsp_ready stalls; writes act at acceptance.
// Selection runs as a tree split over three register stages plus an output register.
// Synchronous active-high reset invalidates all routes and sets infinity to 16.
module ipv4_route_lookup_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [iprl_pkg::INDEX_W-1:0]      req_route_index,
   input  logic [iprl_pkg::ADDR_W-1:0]       req_route_dest,
   input  logic [iprl_pkg::ADDR_W-1:0]       req_route_mask,
   input  logic [iprl_pkg::ADDR_W-1:0]       req_route_gateway,
   input  logic [iprl_pkg::PORT_W-1:0]       req_route_port,
   input  logic [iprl_pkg::METRIC_W-1:0]     req_route_metric,
   input  logic                              req_route_valid,
   input  logic [iprl_pkg::ADDR_W-1:0]       req_dest_addr,
   input  logic [iprl_pkg::TTL_W-1:0]        req_ttl_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [iprl_pkg::STATUS_W-1:0]     rsp_status,
   output logic [iprl_pkg::ADDR_W-1:0]       rsp_next_hop,
   output logic [iprl_pkg::PORT_W-1:0]       rsp_out_port,
   output logic [iprl_pkg::TTL_W-1:0]        rsp_ttl_out,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [iprl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [iprl_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [iprl_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import iprl_pkg::*;

   // Route table.
   logic [ADDR_W-1:0]   tbl_dest_ff    [ROUTES];
   logic [ADDR_W-1:0]   tbl_mask_ff    [ROUTES];
   logic [ADDR_W-1:0]   tbl_gateway_ff [ROUTES];
   logic [PORT_W-1:0]   tbl_port_ff    [ROUTES];
   logic [METRIC_W-1:0] tbl_metric_ff  [ROUTES];
   logic [ROUTES-1:0]   tbl_valid_ff;

   logic [METRIC_W-1:0] infinity_ff;

   // Pipeline registers.
   logic                s1_valid_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [TTL_W-1:0]    s1_ttl_ff;

   logic                s2_valid_ff;
   logic [ADDR_W-1:0]   s2_addr_ff;
   logic [TTL_W-1:0]    s2_ttl_ff;
   cand_type            s2_cand_ff [W1];
   cand_type            s2_cand_in [W1];

   logic                s3_valid_ff;
   logic [ADDR_W-1:0]   s3_addr_ff;
   logic [TTL_W-1:0]    s3_ttl_ff;
   cand_type            s3_cand_ff [W2];
   cand_type            s3_cand_in [W2];

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   logic [ADDR_W-1:0]   rsp_next_hop_ff;
   logic [ADDR_W-1:0]   rsp_next_hop_in;
   logic [PORT_W-1:0]   rsp_out_port_ff;
   logic [PORT_W-1:0]   rsp_out_port_in;
   logic [TTL_W-1:0]    rsp_ttl_out_ff;
   logic [TTL_W-1:0]    rsp_ttl_out_in;

   // Working arrays of the selection tree.
   cand_type            tree1 [LEAVES];
   cand_type            tree2 [W1];
   cand_type            tree3 [W2];
   cand_type            winner;

   logic                out_ready;
   logic                s3_ready;
   logic                s2_ready;
   logic                s1_ready;
   logic                req_fire;
   logic                wr_fire;
   logic                wr_ok;
   logic                cfg_write;

   // Backpressure chain; every stage moves when the one after it can take data.
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign req_fire  = req_valid && req_ready;

   // A route write is dropped when its slot or port lies outside the table.
   assign wr_ok   = (32'(req_route_index) < ROUTES) && (32'(req_route_port) < PORTS);
   assign wr_fire = req_fire && (req_action == ACT_WRITE) && wr_ok;

   // Table payload is written at acceptance of a route write.
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         tbl_dest_ff[req_route_index[IDX_W-1:0]]    <= req_route_dest;
         tbl_mask_ff[req_route_index[IDX_W-1:0]]    <= req_route_mask;
         tbl_gateway_ff[req_route_index[IDX_W-1:0]] <= req_route_gateway;
         tbl_port_ff[req_route_index[IDX_W-1:0]]    <= req_route_port;
         tbl_metric_ff[req_route_index[IDX_W-1:0]]  <= req_route_metric;
      end
   end

   // Valid marks of the table are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (wr_fire) begin
         tbl_valid_ff[req_route_index[IDX_W-1:0]] <= req_route_valid;
      end
   end

   // Configuration register access.
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_INFINITY);
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_INFINITY) ? CSR_DATA_W'(infinity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         infinity_ff <= INFINITY_RESET;
      end else if (cfg_write) begin
         infinity_ff <= pwdata[METRIC_W-1:0];
      end
   end

   // Stage one: match every route against the address and merge the first levels.
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         tree1[i] = '0;
      end
      for (int i = 0; i < ROUTES; i++) begin
         tree1[i].hit     = tbl_valid_ff[i] &&
                            ((s1_addr_ff & tbl_mask_ff[i]) == (tbl_dest_ff[i] & tbl_mask_ff[i]));
         tree1[i].mask    = tbl_mask_ff[i];
         tree1[i].gateway = tbl_gateway_ff[i];
         tree1[i].port    = tbl_port_ff[i];
         tree1[i].metric  = tbl_metric_ff[i];
      end
      for (int l = 0; l < LVL_S1; l++) begin
         for (int j = 0; j < (LEAVES >> (l + 1)); j++) begin
            tree1[j] = pick(tree1[2*j], tree1[2*j+1]);
         end
      end
      for (int j = 0; j < W1; j++) begin
         s2_cand_in[j] = tree1[j];
      end
   end

   // Stage two: middle levels of the tree.
   always_comb begin
      for (int j = 0; j < W1; j++) begin
         tree2[j] = s2_cand_ff[j];
      end
      for (int l = 0; l < LVL_S2; l++) begin
         for (int j = 0; j < (W1 >> (l + 1)); j++) begin
            tree2[j] = pick(tree2[2*j], tree2[2*j+1]);
         end
      end
      for (int j = 0; j < W2; j++) begin
         s3_cand_in[j] = tree2[j];
      end
   end

   // Stage three: last levels, then the forwarding decision.
   always_comb begin
      for (int j = 0; j < W2; j++) begin
         tree3[j] = s3_cand_ff[j];
      end
      for (int l = 0; l < LVL_S3; l++) begin
         for (int j = 0; j < (W2 >> (l + 1)); j++) begin
            tree3[j] = pick(tree3[2*j], tree3[2*j+1]);
         end
      end
      winner = tree3[0];

      rsp_status_in   = ST_FORWARD;
      rsp_next_hop_in = '0;
      rsp_out_port_in = '0;
      rsp_ttl_out_in  = '0;
      priority if (s3_ttl_ff < TTL_MIN_FWD) begin
         rsp_status_in = ST_TIME_EXCEEDED;
      end else if (!winner.hit || (winner.metric == infinity_ff)) begin
         rsp_status_in = ST_NO_ROUTE;
      end else begin
         rsp_next_hop_in = (winner.gateway != '0) ? winner.gateway : s3_addr_ff;
         rsp_out_port_in = winner.port;
         rsp_ttl_out_in  = s3_ttl_ff - TTL_W'(1);
      end
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_fire && (req_action == ACT_LOOKUP);
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Data registers of the pipeline load whenever their stage advances.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_addr_ff <= req_dest_addr;
         s1_ttl_ff  <= req_ttl_in;
      end
      if (s2_ready) begin
         s2_addr_ff <= s1_addr_ff;
         s2_ttl_ff  <= s1_ttl_ff;
         s2_cand_ff <= s2_cand_in;
      end
      if (s3_ready) begin
         s3_addr_ff <= s2_addr_ff;
         s3_ttl_ff  <= s2_ttl_ff;
         s3_cand_ff <= s3_cand_in;
      end
      if (out_ready) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_next_hop_ff <= rsp_next_hop_in;
         rsp_out_port_ff <= rsp_out_port_in;
         rsp_ttl_out_ff  <= rsp_ttl_out_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_next_hop = rsp_next_hop_ff;
   assign rsp_out_port = rsp_out_port_ff;
   assign rsp_ttl_out  = rsp_ttl_out_ff;

endmodule

FILE: tb/ipv4_route_lookup_core_tb.sv
`timescale 1ns / 1ps

module ipv4_route_lookup_core_tb;
   import iprl_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PCT      = 38;
   localparam int STALL_LEN     = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;
   localparam int NET_POOL      = 8;
   // First word index past the register map; writes there must not land anywhere.
   localparam int UNUSED_REG    = 1;

   typedef struct {
      logic                action;
      logic [INDEX_W-1:0]  route_index;
      logic [ADDR_W-1:0]   route_dest;
      logic [ADDR_W-1:0]   route_mask;
      logic [ADDR_W-1:0]   route_gateway;
      logic [PORT_W-1:0]   route_port;
      logic [METRIC_W-1:0] route_metric;
      logic                route_valid;
      logic [ADDR_W-1:0]   dest_addr;
      logic [TTL_W-1:0]    ttl_in;
   } route_req_type;

   typedef struct {
      status_type          status;
      logic [ADDR_W-1:0]   next_hop;
      logic [PORT_W-1:0]   out_port;
      logic [TTL_W-1:0]    ttl_out;
   } route_result_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel.
   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic                req_action        = ACT_WRITE;
   logic [INDEX_W-1:0]  req_route_index   = '0;
   logic [ADDR_W-1:0]   req_route_dest    = '0;
   logic [ADDR_W-1:0]   req_route_mask    = '0;
   logic [ADDR_W-1:0]   req_route_gateway = '0;
   logic [PORT_W-1:0]   req_route_port    = '0;
   logic [METRIC_W-1:0] req_route_metric  = '0;
   logic                req_route_valid   = 1'b0;
   logic [ADDR_W-1:0]   req_dest_addr     = '0;
   logic [TTL_W-1:0]    req_ttl_in        = '0;

   // Response channel.
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_next_hop;
   logic [PORT_W-1:0]   rsp_out_port;
   logic [TTL_W-1:0]    rsp_ttl_out;

   // Register port.
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow routing table and register used for prediction.
   logic [ADDR_W-1:0]   shadow_dest    [ROUTES];
   logic [ADDR_W-1:0]   shadow_mask    [ROUTES];
   logic [ADDR_W-1:0]   shadow_gateway [ROUTES];
   logic [PORT_W-1:0]   shadow_port    [ROUTES];
   logic [METRIC_W-1:0] shadow_metric  [ROUTES];
   logic                shadow_valid   [ROUTES];
   logic [METRIC_W-1:0] shadow_infinity;

   route_result_type  expected_routes[$];
   logic [ADDR_W-1:0] net_pool[NET_POOL];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned stall_left     = 0;
   bit          stall_request  = 1'b0;
   bit          quiet_mode     = 1'b0;

   ipv4_route_lookup_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_route_index   (req_route_index),
      .req_route_dest    (req_route_dest),
      .req_route_mask    (req_route_mask),
      .req_route_gateway (req_route_gateway),
      .req_route_port    (req_route_port),
      .req_route_metric  (req_route_metric),
      .req_route_valid   (req_route_valid),
      .req_dest_addr     (req_dest_addr),
      .req_ttl_in        (req_ttl_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_out_port      (rsp_out_port),
      .rsp_ttl_out       (rsp_ttl_out),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #CLK_HALF clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ipv4_route_lookup_core_tb: errors");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_val, act_val);
      end
   endtask

   // Longest prefix match over the shadow table; higher slot wins on an equal mask.
   function automatic route_result_type predict_route(input logic [ADDR_W-1:0] addr,
                                                      input logic [TTL_W-1:0] ttl);
      route_result_type  res;
      int                best;
      logic [ADDR_W-1:0] best_mask;
      res.status   = ST_NO_ROUTE;
      res.next_hop = '0;
      res.out_port = '0;
      res.ttl_out  = '0;
      best         = -1;
      best_mask    = '0;
      if (ttl < TTL_MIN_FWD) begin
         res.status = ST_TIME_EXCEEDED;
         return res;
      end
      for (int i = 0; i < ROUTES; i++) begin
         if (shadow_valid[i] && ((addr & shadow_mask[i]) == (shadow_dest[i] & shadow_mask[i]))
             && (best < 0 || shadow_mask[i] >= best_mask)) begin
            best      = i;
            best_mask = shadow_mask[i];
         end
      end
      if (best < 0 || shadow_metric[best] == shadow_infinity) begin
         return res;
      end
      res.status   = ST_FORWARD;
      res.next_hop = (shadow_gateway[best] != '0) ? shadow_gateway[best] : addr;
      res.out_port = shadow_port[best];
      res.ttl_out  = ttl - TTL_W'(1);
      return res;
   endfunction

   // Apply an accepted request to the shadow table or queue its lookup result.
   task automatic apply_request(input route_req_type r);
      if (r.action == ACT_WRITE) begin
         if (int'(r.route_index) < ROUTES && int'(r.route_port) < PORTS) begin
            shadow_dest[r.route_index]    = r.route_dest;
            shadow_mask[r.route_index]    = r.route_mask;
            shadow_gateway[r.route_index] = r.route_gateway;
            shadow_port[r.route_index]    = r.route_port;
            shadow_metric[r.route_index]  = r.route_metric;
            shadow_valid[r.route_index]   = r.route_valid;
         end
      end else begin
         expected_routes.push_back(predict_route(r.dest_addr, r.ttl_in));
      end
   endtask

   // Offer one request, with a random idle gap first unless quiet, and wait for acceptance.
   task automatic send_request(input route_req_type r);
      int gap;
      gap = 0;
      if (!quiet_mode) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_action        <= r.action;
      req_route_index   <= r.route_index;
      req_route_dest    <= r.route_dest;
      req_route_mask    <= r.route_mask;
      req_route_gateway <= r.route_gateway;
      req_route_port    <= r.route_port;
      req_route_metric  <= r.route_metric;
      req_route_valid   <= r.route_valid;
      req_dest_addr     <= r.dest_addr;
      req_ttl_in        <= r.ttl_in;
      do @(posedge clock); while (!req_ready);
      apply_request(r);
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait until every lookup has answered, then let the pipeline settle.
   task automatic wait_for_results();
      while (expected_routes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int unsigned reg_idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(reg_idx * 4);
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_idx == REG_INFINITY) shadow_infinity = data[METRIC_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Read the infinity register back and compare with the shadow copy.
   task automatic csr_check_infinity();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(REG_INFINITY * 4);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(shadow_infinity)) begin
         note_mismatch("infinity_metric", CSR_DATA_W'(shadow_infinity), prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
      return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
   endfunction

   function automatic route_req_type make_write(input int idx, input logic [31:0] dest,
                                                input logic [31:0] mask, input logic [31:0] gw,
                                                input int port, input int metric,
                                                input logic valid);
      route_req_type r;
      r.action        = ACT_WRITE;
      r.route_index   = INDEX_W'(idx);
      r.route_dest    = dest;
      r.route_mask    = mask;
      r.route_gateway = gw;
      r.route_port    = PORT_W'(port);
      r.route_metric  = METRIC_W'(metric);
      r.route_valid   = valid;
      // Lookup fields carry noise that the block must ignore.
      r.dest_addr     = $urandom;
      r.ttl_in        = TTL_W'($urandom);
      return r;
   endfunction

   function automatic route_req_type make_lookup(input logic [31:0] addr, input int ttl);
      route_req_type r;
      r.action        = ACT_LOOKUP;
      // Route fields carry noise that the block must ignore.
      r.route_index   = INDEX_W'($urandom);
      r.route_dest    = $urandom;
      r.route_mask    = $urandom;
      r.route_gateway = $urandom;
      r.route_port    = PORT_W'($urandom);
      r.route_metric  = METRIC_W'($urandom);
      r.route_valid   = 1'($urandom);
      r.dest_addr     = addr;
      r.ttl_in        = TTL_W'(ttl);
      return r;
   endfunction

   // Random request: writes build overlapping prefixes, lookups mostly hit the table.
   function automatic route_req_type random_request();
      route_req_type     r;
      logic [ADDR_W-1:0] mask;
      int                slot;
      int                pick;
      int                ttl_sel;
      if ($urandom_range(99) < 30) begin
         mask = ($urandom_range(9) == 0) ? ADDR_W'($urandom) : prefix_mask($urandom_range(32));
         r = make_write($urandom_range(ROUTES - 1),
                        (net_pool[$urandom_range(NET_POOL - 1)] & mask) | ($urandom & ~mask),
                        mask,
                        ($urandom_range(3) == 0) ? 32'h0 : 32'($urandom),
                        $urandom_range(PORTS - 1),
                        ($urandom_range(3) == 0) ? int'(shadow_infinity) : $urandom_range(31),
                        $urandom_range(6) != 0);
      end else begin
         pick    = $urandom_range(9);
         ttl_sel = $urandom_range(19);
         r = make_lookup($urandom, $urandom_range(255));
         if (pick < 7) begin
            slot = $urandom_range(ROUTES - 1);
            r.dest_addr = (shadow_dest[slot] & shadow_mask[slot]) | ($urandom & ~shadow_mask[slot]);
         end else if (pick < 9) begin
            r.dest_addr = net_pool[$urandom_range(NET_POOL - 1)] ^ ADDR_W'($urandom_range(255));
         end
         if (ttl_sel < 4) begin
            r.ttl_in = (ttl_sel == 3) ? 8'hFF : TTL_W'(ttl_sel);
         end
      end
      return r;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   // Response side: random back-pressure plus a long hold-off on request.
   always @(negedge clock) begin
      if (stall_request) begin
         stall_left    = STALL_LEN;
         stall_request = 1'b0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted response with the oldest outstanding lookup.
   always @(posedge clock) begin : check_responses
      route_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_routes.size() == 0) begin
            note_mismatch("unexpected response status", '0, 32'(rsp_status));
         end else begin
            exp_res = expected_routes.pop_front();
            if (rsp_status !== exp_res.status)
               note_mismatch("status", 32'(exp_res.status), 32'(rsp_status));
            if (rsp_next_hop !== exp_res.next_hop)
               note_mismatch("next_hop", exp_res.next_hop, rsp_next_hop);
            if (rsp_out_port !== exp_res.out_port)
               note_mismatch("out_port", 32'(exp_res.out_port), 32'(rsp_out_port));
            if (rsp_ttl_out !== exp_res.ttl_out)
               note_mismatch("ttl_out", 32'(exp_res.ttl_out), 32'(rsp_ttl_out));
         end
      end
   end

   // Empty table after reset: nothing routes, low TTLs expire, register at default.
   task automatic test_empty_table();
      csr_check_infinity();
      send_request(make_lookup(32'hC0A8_0001, 64));
      send_request(make_lookup(32'h0000_0000, 0));
      send_request(make_lookup(32'hFFFF_FFFF, 1));
   endtask

   // Hand-built table covering prefix length, ties, gateways and unreachable routes.
   task automatic test_directed_routes();
      // Default route through a gateway.
      send_request(make_write(0, 32'h0, 32'h0, 32'h0A00_0001, 0, 1, 1'b1));
      send_request(make_lookup(32'hFFFF_FFFF, 255));
      // Nested prefixes: the /8 is direct, the /24 is unreachable.
      send_request(make_write(3, 32'h0A00_0000, prefix_mask(8), 32'h0, 1, 2, 1'b1));
      send_request(make_write(7, 32'h0A01_0000, prefix_mask(16), 32'hFFFF_FFFF, 2, 31, 1'b1));
      send_request(make_write(12, 32'h0A01_0200, prefix_mask(24), 32'hC000_0001, 3, 16, 1'b1));
      send_request(make_lookup(32'h0A01_0203, 2));
      send_request(make_lookup(32'h0A01_0909, 2));
      send_request(make_lookup(32'h0AC8_0001, 100));
      // Equal masks: the higher slot wins, the lower one never does.
      send_request(make_write(15, 32'h0A01_0000, prefix_mask(16), 32'h0102_0304, 0, 0, 1'b1));
      send_request(make_lookup(32'h0A01_4D01, 3));
      send_request(make_write(2, 32'h0A01_0000, prefix_mask(16), 32'h0506_0708, 3, 4, 1'b1));
      send_request(make_lookup(32'h0A01_0505, 255));
      // Host route written invalid first, then made valid.
      send_request(make_write(9, 32'h0A01_0203, prefix_mask(32), 32'h0, 1, 5, 1'b0));
      send_request(make_lookup(32'h0A01_0203, 3));
      send_request(make_write(9, 32'h0A01_0203, prefix_mask(32), 32'h0, 1, 5, 1'b1));
      send_request(make_lookup(32'h0A01_0203, 3));
      send_request(make_lookup(32'h0A01_0203, 1));
      // A non-contiguous mask ranks by its numeric value.
      send_request(make_write(4, 32'hAB00_CD00, 32'hFF00_FF00, 32'h55AA_55AA, 2, 3, 1'b1));
      send_request(make_lookup(32'hAB12_CD34, 9));
      // Dropping the default route leaves unmatched addresses without a route.
      send_request(make_write(0, 32'h0, 32'h0, 32'h0A00_0001, 0, 1, 1'b0));
      send_request(make_lookup(32'h7F00_0001, 64));
   endtask

   // Random traffic under the lowest, the highest and a random infinity setting.
   task automatic test_infinity_settings();
      logic [CSR_DATA_W-1:0] settings[3];
      settings[0] = 32'hFFFF_FFE0;
      settings[1] = 32'h0000_001F;
      settings[2] = $urandom;
      foreach (settings[i]) begin
         park_sender();
         wait_for_results();
         csr_write(REG_INFINITY, settings[i]);
         csr_check_infinity();
         run_random(150);
      end
   endtask

   // A write past the register map must leave the infinity register alone.
   task automatic test_unused_register();
      park_sender();
      wait_for_results();
      csr_write(UNUSED_REG, $urandom);
      csr_check_infinity();
      csr_write(REG_INFINITY, CSR_DATA_W'(INFINITY_RESET));
      csr_check_infinity();
      run_random(50);
   endtask

   // Back-to-back requests with no idling on either side.
   task automatic test_back_to_back();
      quiet_mode = 1'b1;
      run_random(200);
      quiet_mode = 1'b0;
   endtask

   // Long response hold-off while requests keep coming, so the input stalls.
   task automatic test_output_stall();
      stall_request = 1'b1;
      quiet_mode    = 1'b1;
      run_random(150);
      quiet_mode    = 1'b0;
   endtask

   // Sender stops until every response is in, then resumes.
   task automatic test_drain_pause();
      run_random(100);
      park_sender();
      wait_for_results();
      run_random(150);
   endtask

   task automatic test_mixed_traffic();
      run_random(150);
   endtask

   initial begin
      for (int i = 0; i < ROUTES; i++) begin
         shadow_dest[i]    = '0;
         shadow_mask[i]    = '0;
         shadow_gateway[i] = '0;
         shadow_port[i]    = '0;
         shadow_metric[i]  = '0;
         shadow_valid[i]   = 1'b0;
      end
      shadow_infinity = INFINITY_RESET;
      // Half the pool shares one /8 so random prefixes overlap.
      for (int i = 0; i < NET_POOL; i++) begin
         net_pool[i] = (i < NET_POOL / 2) ? {8'h0A, 24'($urandom)} : ADDR_W'($urandom);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_directed_routes();
      test_infinity_settings();
      test_unused_register();
      test_back_to_back();
      test_output_stall();
      test_drain_pause();
      test_mixed_traffic();

      park_sender();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("ipv4_route_lookup_core_tb: clean");
      end else begin
         $display("ipv4_route_lookup_core_tb: errors");
      end
      $finish;
   end

endmodule
